// ----- rtl/ctc_pkg.sv -----
// ctc_pkg: shared types, constants and helpers of the calendar time counter
// used by ctc_leap, ctc_next and calendar_time_counter; no dependencies

package ctc_pkg;

	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;

	localparam logic [SEC_W-1:0]   SEC_PER_MIN     = 6'd60;
	localparam logic [MIN_W-1:0]   MIN_PER_HOUR    = 6'd60;
	localparam logic [HOUR_W-1:0]  HOURS_PER_DAY   = 5'd24;
	localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
	localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS   = 5'd29;
	localparam logic [DAY_W-1:0]   LONG_MONTH_DAYS = 5'd31;

	// reset values of the counters
	localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
	localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
	localparam logic [YEAR_W-1:0]  RST_YEAR  = 16'd2000;
	localparam logic               RST_LEAP  = 1'b1;

	// divisibility by 25: y * inverse(25) mod 2^16 lands at or below 65535/25
	localparam logic [YEAR_W-1:0] INV25   = 16'd23593;
	localparam logic [YEAR_W-1:0] MAX_Q25 = 16'd2621;

	localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} ctc_op_t;

	typedef struct packed {
		logic [SEC_W-1:0]   second;
		logic [MIN_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               colon;
	} ctc_state_t;

	typedef struct packed {
		ctc_op_t            opcode;
		logic [SEC_W-1:0]   second;
		logic [MIN_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               leap;
	} ctc_item_t;

	// days in month m; a month outside 1..12 counts as a long month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [MONTH_W-1:0] idx;
		idx = m - 4'd1;
		if (m < 4'd1 || m > MONTHS_PER_YEAR) begin
			return LONG_MONTH_DAYS;
		end else if (m == MONTH_FEB && leap) begin
			return FEB_LEAP_DAYS;
		end else begin
			return MONTH_DAYS[idx];
		end
	endfunction

endpackage

// ----- rtl/ctc_leap.sv -----
// ctc_leap: gregorian leap year test (400/100/4 rule) on a 16-bit year
// depends on ctc_pkg

module ctc_leap (
	input  logic [ctc_pkg::YEAR_W-1:0] year,
	output logic                       leap
);

	logic [ctc_pkg::YEAR_W-1:0] prod;
	logic                       div25;

	// exact multiple of 25 test by modular inverse, product kept mod 2^16
	assign prod  = year * ctc_pkg::INV25;
	assign div25 = prod <= ctc_pkg::MAX_Q25;

	// multiple of 25 and 4 is a century: then it must divide by 16 (i.e. 400)
	assign leap = div25 ? (year[3:0] == 4'd0) : (year[1:0] == 2'd0);

endmodule

// ----- rtl/ctc_next.sv -----
// ctc_next: next calendar state for one tick or load, plus load validation
// depends on ctc_pkg

module ctc_next (
	input  ctc_pkg::ctc_state_t cur,
	input  logic                cur_leap,
	input  ctc_pkg::ctc_item_t  item,
	output ctc_pkg::ctc_state_t nxt,
	output logic                rejected
);

	logic [ctc_pkg::SEC_W:0]     sec_inc;
	logic [ctc_pkg::MIN_W:0]     min_inc;
	logic [ctc_pkg::HOUR_W:0]    hour_inc;
	logic [ctc_pkg::DAY_W:0]     day_inc;
	logic [ctc_pkg::MONTH_W:0]   month_inc;
	logic [ctc_pkg::DAY_W-1:0]   cur_len;
	logic [ctc_pkg::DAY_W-1:0]   new_len;
	logic                        load_ok;

	assign sec_inc   = {1'b0, cur.second} + 7'd1;
	assign min_inc   = {1'b0, cur.minute} + 7'd1;
	assign hour_inc  = {1'b0, cur.hour} + 6'd1;
	assign day_inc   = {1'b0, cur.day} + 6'd1;
	assign month_inc = {1'b0, cur.month} + 5'd1;
	assign cur_len   = ctc_pkg::month_len(cur.month, cur_leap);
	assign new_len   = ctc_pkg::month_len(item.month, item.leap);

	assign load_ok = item.second < ctc_pkg::SEC_PER_MIN
		&& item.minute < ctc_pkg::MIN_PER_HOUR
		&& item.hour < ctc_pkg::HOURS_PER_DAY
		&& item.month >= 4'd1 && item.month <= ctc_pkg::MONTHS_PER_YEAR
		&& item.day >= 5'd1 && item.day <= new_len;

	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		case (item.opcode)
			ctc_pkg::OP_TICK: begin
				nxt.colon = ~cur.colon;
				if (sec_inc >= {1'b0, ctc_pkg::SEC_PER_MIN}) begin
					nxt.second = '0;
					if (min_inc >= {1'b0, ctc_pkg::MIN_PER_HOUR}) begin
						nxt.minute = '0;
						if (hour_inc >= {1'b0, ctc_pkg::HOURS_PER_DAY}) begin
							nxt.hour = '0;
							if (day_inc > {1'b0, cur_len}) begin
								nxt.day = 5'd1;
								if (month_inc > {1'b0, ctc_pkg::MONTHS_PER_YEAR}) begin
									nxt.month = 4'd1;
									nxt.year  = cur.year + 16'd1;
								end else begin
									nxt.month = month_inc[ctc_pkg::MONTH_W-1:0];
								end
							end else begin
								nxt.day = day_inc[ctc_pkg::DAY_W-1:0];
							end
						end else begin
							nxt.hour = hour_inc[ctc_pkg::HOUR_W-1:0];
						end
					end else begin
						nxt.minute = min_inc[ctc_pkg::MIN_W-1:0];
					end
				end else begin
					nxt.second = sec_inc[ctc_pkg::SEC_W-1:0];
				end
			end
			ctc_pkg::OP_LOAD: begin
				if (load_ok) begin
					nxt.second = item.second;
					nxt.minute = item.minute;
					nxt.hour   = item.hour;
					nxt.day    = item.day;
					nxt.month  = item.month;
					nxt.year   = item.year;
				end else begin
					rejected = 1'b1;
				end
			end
			default: begin
				rejected = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/calendar_time_counter.sv -----
// calendar_time_counter: top level of the real-time clock calendar counter
// depends on ctc_pkg, ctc_leap and ctc_next

// Real-time clock calendar counter on stream buses. Each input transaction is
// either a one-second tick (s_axis_tuser = 0) or a load of a full time and
// date (s_axis_tuser = 1). A tick advances second, minute, hour, day, month
// and year in cascade with gregorian month lengths (February has 29 days in
// leap years by the 400/100/4 rule, year 0 included), the year wraps from
// 65535 to 0, and the colon flag toggles. A load with a field out of range, or
// a day past the end of that month, leaves the calendar unchanged and comes
// back with m_axis_tuser = 1. Every input transaction gives exactly one output
// transaction showing the calendar after it. After reset the calendar reads
// 2000-01-01 00:00:00 with the colon flag low. Timing: a transaction passes
// through the input register and then the calendar/result register, which
// drives the output; a new transaction can be accepted every cycle while the
// output is not stalled, and the tick cascade between the input register and
// the calendar/result register is combinational. While a result waits on
// m_axis_tready the input register takes at most one more transaction, then
// s_axis_tready stays low until the waiting result is taken.

module calendar_time_counter (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// new_second[5:0], new_minute[11:6], new_hour[16:12], new_day[21:17],
	// new_month[25:22], new_year[41:26], zero fill [47:42]
	input  logic [47:0] s_axis_tdata,
	// opcode: 0 = tick, 1 = load
	input  logic        s_axis_tuser,
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// second_now[5:0], minute_now[11:6], hour_now[16:12], day_now[21:17],
	// month_now[25:22], year_now[41:26], colon_on[42], zero fill [47:43]
	output logic [47:0] m_axis_tdata,
	// load_rejected
	output logic        m_axis_tuser
);

	// input stage
	logic                s1_valid_s1;
	ctc_pkg::ctc_item_t  item_s1;
	ctc_pkg::ctc_item_t  item_in;
	logic                in_leap;

	// calendar state doubles as the result register: a result is always
	// the calendar after its transaction
	ctc_pkg::ctc_state_t cal_q;
	logic                rej_q;
	logic                out_valid_q;
	logic                cur_leap_q;

	logic                cal_leap;
	logic                advance;
	ctc_pkg::ctc_state_t cal_nxt;
	logic                rej_nxt;

	// leap flag of the incoming load year, found before the input register
	ctc_leap u_leap_in (
		.year (s_axis_tdata[41:26]),
		.leap (in_leap)
	);

	// leap flag of the running year, registered, so it catches up with a year
	// change in the cycle after; a carry into a new year lands in January so the
	// lag never matters, and a load sets the flag directly
	ctc_leap u_leap_cal (
		.year (cal_q.year),
		.leap (cal_leap)
	);

	always_comb begin
		item_in.opcode = ctc_pkg::ctc_op_t'(s_axis_tuser);
		item_in.second = s_axis_tdata[5:0];
		item_in.minute = s_axis_tdata[11:6];
		item_in.hour   = s_axis_tdata[16:12];
		item_in.day    = s_axis_tdata[21:17];
		item_in.month  = s_axis_tdata[25:22];
		item_in.year   = s_axis_tdata[41:26];
		item_in.leap   = in_leap;
	end

	ctc_next u_next (
		.cur      (cal_q),
		.cur_leap (cur_leap_q),
		.item     (item_s1),
		.nxt      (cal_nxt),
		.rejected (rej_nxt)
	);

	// input stage moves on when the result register is free or being drained
	assign advance       = s1_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	// input payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rej_q       <= 1'b0;
			cur_leap_q  <= ctc_pkg::RST_LEAP;
			cal_q       <= '{second: '0, minute: '0, hour: '0,
				day: ctc_pkg::RST_DAY, month: ctc_pkg::RST_MONTH,
				year: ctc_pkg::RST_YEAR, colon: 1'b0};
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				cal_q       <= cal_nxt;
				rej_q       <= rej_nxt;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// accepted load: take its precomputed leap flag at once
			if (advance && item_s1.opcode == ctc_pkg::OP_LOAD && !rej_nxt) begin
				cur_leap_q <= item_s1.leap;
			end else begin
				cur_leap_q <= cal_leap;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = rej_q;
	assign m_axis_tdata  = {5'd0, cal_q.colon, cal_q.year, cal_q.month, cal_q.day,
		cal_q.hour, cal_q.minute, cal_q.second};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench of calendar_time_counter, with its own calendar
// predictor, directed rollover, leap-year and bad-load cases, then random traffic
// depends on ctc_pkg and calendar_time_counter

module tb_top;
	import ctc_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int FILL_W = 48 - (SEC_W + MIN_W + HOUR_W + DAY_W + MONTH_W + YEAR_W);

	// one input transaction: tick or load of a full time and date
	typedef struct packed {
		ctc_op_t            op;
		logic [SEC_W-1:0]   second;
		logic [MIN_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} clock_cmd_t;

	// one output transaction: calendar after the command plus the reject flag
	typedef struct packed {
		ctc_state_t cal;
		logic       rejected;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = OP_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;

	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         fault_count = 0;
	int         cycle_count = 0;
	ctc_state_t calendar_model;
	reading_t   pending_readings[$];

	calendar_time_counter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// gregorian rule: every 400th year leap, other centuries not, else every 4th
	function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
		int unsigned v;
		v = y;
		return (v % 400 == 0) || ((v % 100 != 0) && (v % 4 == 0));
	endfunction

	function automatic int unsigned last_day(input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		case (m)
			4'd2: return is_leap_year(y) ? 29 : 28;
			4'd4, 4'd6, 4'd9, 4'd11: return 30;
			default: return 31;
		endcase
	endfunction

	// applies one command to the model calendar and returns the reading it gives
	function automatic reading_t advance_calendar(input clock_cmd_t cmd);
		reading_t          r;
		int unsigned       s, mi, h, d, mo;
		logic [YEAR_W-1:0] y;
		r.rejected = 1'b0;
		if (cmd.op == OP_TICK) begin
			s  = calendar_model.second + 1;
			mi = calendar_model.minute;
			h  = calendar_model.hour;
			d  = calendar_model.day;
			mo = calendar_model.month;
			y  = calendar_model.year;
			// cascade of carries, year wraps at its width
			if (s >= 60) begin
				s = 0;
				mi++;
				if (mi >= 60) begin
					mi = 0;
					h++;
					if (h >= 24) begin
						h = 0;
						d++;
						if (d > last_day(MONTH_W'(mo), y)) begin
							d = 1;
							mo++;
							if (mo > 12) begin
								mo = 1;
								y  = y + 1'b1;
							end
						end
					end
				end
			end
			calendar_model.second = SEC_W'(s);
			calendar_model.minute = MIN_W'(mi);
			calendar_model.hour   = HOUR_W'(h);
			calendar_model.day    = DAY_W'(d);
			calendar_model.month  = MONTH_W'(mo);
			calendar_model.year   = y;
			calendar_model.colon  = ~calendar_model.colon;
		end else if (cmd.second < 60 && cmd.minute < 60 && cmd.hour < 24 &&
				cmd.month >= 1 && cmd.month <= 12 &&
				cmd.day >= 1 && cmd.day <= last_day(cmd.month, cmd.year)) begin
			calendar_model.second = cmd.second;
			calendar_model.minute = cmd.minute;
			calendar_model.hour   = cmd.hour;
			calendar_model.day    = cmd.day;
			calendar_model.month  = cmd.month;
			calendar_model.year   = cmd.year;
		end else begin
			r.rejected = 1'b1;
		end
		r.cal = calendar_model;
		return r;
	endfunction

	function automatic clock_cmd_t load_cmd(input int unsigned s, mi, h, d, mo, y);
		clock_cmd_t c;
		c.op     = OP_LOAD;
		c.second = SEC_W'(s);
		c.minute = MIN_W'(mi);
		c.hour   = HOUR_W'(h);
		c.day    = DAY_W'(d);
		c.month  = MONTH_W'(mo);
		c.year   = YEAR_W'(y);
		return c;
	endfunction

	// a tick carries random payload, which the block must ignore
	function automatic clock_cmd_t tick_cmd();
		clock_cmd_t c;
		c      = load_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		c.op   = OP_TICK;
		return c;
	endfunction

	// valid load; near_edge pushes it close to minute, day, month and year rollovers
	function automatic clock_cmd_t random_valid_load(input bit near_edge);
		int unsigned y, mo, top;
		case ($urandom_range(5))
			0: y = 65535;
			1: y = 0;
			2: y = $urandom_range(655) * 100;
			3: y = $urandom_range(16383) * 4;
			default: y = $urandom_range(65535);
		endcase
		if (near_edge && $urandom_range(2) == 0) begin
			mo = $urandom_range(1) ? 12 : 2;
		end else begin
			mo = $urandom_range(1, 12);
		end
		top = last_day(MONTH_W'(mo), YEAR_W'(y));
		if (near_edge) begin
			return load_cmd($urandom_range(3) ? 59 : $urandom_range(59),
				$urandom_range(3) ? 59 : $urandom_range(59),
				$urandom_range(3) ? 23 : $urandom_range(23),
				$urandom_range(2) ? top : $urandom_range(1, top), mo, y);
		end
		return load_cmd($urandom_range(59), $urandom_range(59), $urandom_range(23),
			$urandom_range(1, top), mo, y);
	endfunction

	// drives one input transaction at the falling edge, waits for acceptance
	task automatic send_cmd(input clock_cmd_t cmd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd.op;
		s_axis_tdata  <= {{FILL_W{1'b0}}, cmd.year, cmd.month, cmd.day, cmd.hour,
			cmd.minute, cmd.second};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_readings.push_back(advance_calendar(cmd));
	endtask

	function automatic void log_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("%t mismatch in %s: expected %0d, got %0d", $realtime, field, want,
				got);
		end
	endfunction

	// output side: random back-pressure set at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// output side: every accepted transaction is checked against the oldest prediction
	always @(posedge clk) begin : result_check
		reading_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			{got.cal.colon, got.cal.year, got.cal.month, got.cal.day, got.cal.hour,
				got.cal.minute, got.cal.second} = m_axis_tdata[42:0];
			got.rejected = m_axis_tuser;
			if (pending_readings.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS) begin
					$display("%t unexpected output transaction %h / %b", $realtime,
						m_axis_tdata, m_axis_tuser);
				end
			end else begin
				want = pending_readings.pop_front();
				if (got.cal.second !== want.cal.second)
					log_mismatch("second", 32'(want.cal.second), 32'(got.cal.second));
				if (got.cal.minute !== want.cal.minute)
					log_mismatch("minute", 32'(want.cal.minute), 32'(got.cal.minute));
				if (got.cal.hour !== want.cal.hour)
					log_mismatch("hour", 32'(want.cal.hour), 32'(got.cal.hour));
				if (got.cal.day !== want.cal.day)
					log_mismatch("day", 32'(want.cal.day), 32'(got.cal.day));
				if (got.cal.month !== want.cal.month)
					log_mismatch("month", 32'(want.cal.month), 32'(got.cal.month));
				if (got.cal.year !== want.cal.year)
					log_mismatch("year", 32'(want.cal.year), 32'(got.cal.year));
				if (got.cal.colon !== want.cal.colon)
					log_mismatch("colon", 32'(want.cal.colon), 32'(got.cal.colon));
				if (got.rejected !== want.rejected)
					log_mismatch("load_rejected", 32'(want.rejected), 32'(got.rejected));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** calendar_time_counter: FAILED **");
			$finish;
		end
	end

	task automatic test_after_reset();
		// first second after reset, colon goes high
		send_cmd(tick_cmd());
		// all-minimum load
		send_cmd(load_cmd(0, 0, 0, 1, 1, 0));
	endtask

	task automatic test_rollovers();
		// full cascade with year wrap to 0
		send_cmd(load_cmd(59, 59, 23, 31, 12, 65535));
		send_cmd(tick_cmd());
		// end of a 30-day month
		send_cmd(load_cmd(59, 59, 23, 30, 4, 2023));
		send_cmd(tick_cmd());
	endtask

	task automatic test_leap_rules();
		// year 0 is leap
		send_cmd(load_cmd(59, 59, 23, 28, 2, 0));
		send_cmd(tick_cmd());
		// 400-rule leap, 100-rule non-leap on load
		send_cmd(load_cmd(0, 0, 0, 29, 2, 2000));
		send_cmd(load_cmd(0, 0, 0, 29, 2, 1900));
		// leap february ends on the 29th
		send_cmd(load_cmd(59, 59, 23, 29, 2, 2024));
		send_cmd(tick_cmd());
		// century non-leap february ends on the 28th
		send_cmd(load_cmd(59, 59, 23, 28, 2, 2100));
		send_cmd(tick_cmd());
	endtask

	task automatic test_rejected_loads();
		send_cmd(load_cmd(60, 0, 0, 1, 1, 2001));
		send_cmd(load_cmd(63, 0, 0, 1, 1, 2001));
		send_cmd(load_cmd(0, 60, 0, 1, 1, 2001));
		send_cmd(load_cmd(0, 63, 0, 1, 1, 2001));
		send_cmd(load_cmd(0, 0, 24, 1, 1, 2001));
		send_cmd(load_cmd(0, 0, 31, 1, 1, 2001));
		send_cmd(load_cmd(0, 0, 0, 1, 0, 2001));
		send_cmd(load_cmd(0, 0, 0, 1, 13, 2001));
		send_cmd(load_cmd(0, 0, 0, 1, 15, 2001));
		send_cmd(load_cmd(0, 0, 0, 0, 1, 2001));
		send_cmd(load_cmd(0, 0, 0, 31, 4, 2001));
	endtask

	// mostly loads near a rollover followed by a few ticks, plus tick runs,
	// loads with one bad field and raw random loads
	task automatic test_random_traffic(input int count);
		int          sent;
		int          kind;
		int unsigned top;
		clock_cmd_t  c;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				send_cmd(random_valid_load(1'b1));
				sent++;
				repeat ($urandom_range(1, 4)) begin
					send_cmd(tick_cmd());
					sent++;
				end
			end else if (kind < 65) begin
				repeat ($urandom_range(1, 8)) begin
					send_cmd(tick_cmd());
					sent++;
				end
			end else if (kind < 85) begin
				c   = random_valid_load(1'b0);
				top = last_day(c.month, c.year);
				case ($urandom_range(4))
					0: c.second = SEC_W'($urandom_range(60, 63));
					1: c.minute = MIN_W'($urandom_range(60, 63));
					2: c.hour   = HOUR_W'($urandom_range(24, 31));
					3: c.month  = $urandom_range(1) ? '0 : MONTH_W'($urandom_range(13, 15));
					default: c.day = (top < 31 && $urandom_range(1)) ?
						DAY_W'($urandom_range(top + 1, 31)) : '0;
				endcase
				send_cmd(c);
				sent++;
			end else begin
				send_cmd(load_cmd($urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom));
				sent++;
			end
		end
	endtask

	initial begin
		calendar_model = '{second: '0, minute: '0, hour: '0, day: RST_DAY,
			month: RST_MONTH, year: RST_YEAR, colon: 1'b0};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles little, receiver stalls often
		send_idle_pct = 24;
		recv_idle_pct = 67;
		test_after_reset();
		test_rollovers();
		test_leap_rules();
		test_rejected_loads();
		test_random_traffic(700);

		// the other way round
		send_idle_pct = 67;
		recv_idle_pct = 24;
		test_random_traffic(700);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(700);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("** calendar_time_counter: PASSED **");
		end else begin
			$display("** calendar_time_counter: FAILED **");
		end
		$finish;
	end

endmodule
